@@ sv/gpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamma correction package
// Shared widths, stage payload types and the constant tables for the
// logarithm lookup and the fractional power-of-two roots.
// ----------------------------------------------------------------------------
package gpc_pkg;

  // Pixel and fixed-point formats.
  localparam int PIXEL_BITS = 8;
  localparam int PIXEL_MAX  = (1 << PIXEL_BITS) - 1;
  localparam int FRAC_BITS  = 16;
  localparam int Q_BITS     = 30;
  localparam int LOG_BITS   = 20;
  localparam int EXP_BITS   = 16;
  localparam int PROD_BITS  = LOG_BITS + EXP_BITS;
  localparam int Y_BITS     = PROD_BITS - 12;
  localparam int IPART_BITS = Y_BITS - FRAC_BITS;
  localparam int SHIFT_BITS = 6;
  localparam int SHIFT_LIMIT = 40;
  localparam int MANT_BITS  = Q_BITS + 1;
  localparam int ROOT_BITS  = Q_BITS;
  localparam int SCALE_BITS = MANT_BITS + PIXEL_BITS - 1;

  localparam logic [EXP_BITS-1:0]  IDENTITY_EXP = EXP_BITS'(4096);
  localparam logic [MANT_BITS-1:0] ONE_Q30      = MANT_BITS'(64'd1 << Q_BITS);

  // Register stages: three in the log/scale front end, one per fraction bit
  // in the exponential chain and two in the output stage.
  localparam int FRONT_STAGES = 3;
  localparam int OUT_STAGES   = 2;
  localparam int PIPE_DEPTH   = FRONT_STAGES + FRAC_BITS + OUT_STAGES;

  // Result forced by a special case, or computed normally.
  typedef enum logic [1:0] {
    OVR_NONE,
    OVR_ZERO,
    OVR_FULL
  } override_t;

  // Payload carried through the exponential chain.
  typedef struct packed {
    logic [MANT_BITS-1:0]  mant;
    logic [FRAC_BITS-1:0]  frac;
    logic [SHIFT_BITS-1:0] ipart;
    override_t             ovr;
    logic                  frame_end;
  } exp_item_t;

  typedef logic [LOG_BITS-1:0]  log_table_t  [1 << PIXEL_BITS];
  typedef logic [ROOT_BITS-1:0] root_table_t [FRAC_BITS + 1];

  // Floor square root, used only while building the constant tables.
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bitv;
    n    = n_in;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (bitv > n) begin
        bitv = bitv >> 2;
      end
    end
    for (int s = 0; s < 32; s++) begin
      if (bitv != 64'd0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // Q.16 base-2 logarithm by repeated squaring of the mantissa.
  function automatic logic [LOG_BITS-1:0] log2_q16(input int unsigned x);
    int unsigned         k;
    logic [63:0]         m;
    logic [LOG_BITS-1:0] res;
    k = 0;
    for (int s = 0; s < 31; s++) begin
      if ((x >> (k + 1)) != 0) begin
        k++;
      end
    end
    m   = 64'(x) << (Q_BITS - k);
    res = LOG_BITS'(k) << FRAC_BITS;
    for (int b = FRAC_BITS - 1; b >= 0; b--) begin
      m = (m * m) >> Q_BITS;
      if (m >= (64'd1 << (Q_BITS + 1))) begin
        m      = m >> 1;
        res[b] = 1'b1;
      end
    end
    return res;
  endfunction

  // -log2(p / PIXEL_MAX) in Q.16 for every nonzero pixel code, clamped at zero; code zero maps to zero.
  function automatic log_table_t build_log_table();
    log_table_t          tab;
    logic [LOG_BITS-1:0] lf;
    logic [LOG_BITS-1:0] lp;
    lf = log2_q16(PIXEL_MAX);
    tab[0] = '0;
    for (int p = 1; p <= PIXEL_MAX; p++) begin
      lp = log2_q16(p);
      tab[p] = (lp > lf) ? '0 : LOG_BITS'(lf - lp);
    end
    return tab;
  endfunction

  // Roots 2^30 * 2^(-2^-j), each the square root of the one before.
  function automatic root_table_t build_root_table();
    root_table_t tab;
    logic [63:0] c;
    c = 64'd1 << (Q_BITS - 1);
    tab[0] = ROOT_BITS'(c);
    for (int j = 1; j <= FRAC_BITS; j++) begin
      c = isqrt64(c << Q_BITS);
      tab[j] = ROOT_BITS'(c);
    end
    return tab;
  endfunction

  localparam log_table_t  LOG_TABLE  = build_log_table();
  localparam root_table_t ROOT_TABLE = build_root_table();

endpackage

@@ sv/gpc_log_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamma correction front end
// Looks up the pixel logarithm, scales it by the exponent register and splits
// the result into integer and fraction parts, over three register stages.
// ----------------------------------------------------------------------------
module gpc_log_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [gpc_pkg::EXP_BITS-1:0]      inverse_gamma,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gpc_pkg::PIXEL_BITS-1:0]    in_pixel,
  input  logic                              in_frame_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gpc_pkg::exp_item_t                out_item
);
  import gpc_pkg::*;

  logic                  valid1;
  logic                  valid2;
  logic                  valid3;
  logic                  ready1;
  logic                  ready2;
  logic                  ready3;
  logic [LOG_BITS-1:0]   log1;
  logic                  pzero1;
  logic                  fe1;
  logic [Y_BITS-1:0]     y2;
  logic                  pzero2;
  logic                  ezero2;
  logic                  fe2;
  logic [PROD_BITS-1:0]  prod;
  logic [IPART_BITS-1:0] ipart;
  exp_item_t             item_next;
  exp_item_t             item3;

  // A stage takes new data when it is empty or its content moves on.
  assign ready3   = !valid3 || out_ready;
  assign ready2   = !valid2 || ready3;
  assign ready1   = !valid1 || ready2;
  assign in_ready = ready1;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (ready1) valid1 <= in_valid;
      if (ready2) valid2 <= valid1;
      if (ready3) valid3 <= valid2;
    end
  end

  // Stage 1: logarithm lookup.
  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      log1   <= LOG_TABLE[in_pixel];
      pzero1 <= (in_pixel == '0);
      fe1    <= in_frame_end;
    end
  end

  // Stage 2: multiply by the exponent and drop twelve fraction bits.
  assign prod = PROD_BITS'(log1) * PROD_BITS'(inverse_gamma);

  always_ff @(posedge clk) begin
    if (ready2 && valid1) begin
      y2     <= prod[PROD_BITS-1:12];
      pzero2 <= pzero1;
      ezero2 <= (inverse_gamma == '0);
      fe2    <= fe1;
    end
  end

  // Stage 3: split into shift and fraction and resolve the special cases.
  assign ipart = y2[Y_BITS-1:FRAC_BITS];

  always_comb begin
    item_next.mant      = ONE_Q30;
    item_next.frac      = y2[FRAC_BITS-1:0];
    item_next.ipart     = ipart[SHIFT_BITS-1:0];
    item_next.frame_end = fe2;
    if (ezero2) begin
      item_next.ovr = OVR_FULL;
    end else if (pzero2 || (ipart >= IPART_BITS'(SHIFT_LIMIT))) begin
      item_next.ovr = OVR_ZERO;
    end else begin
      item_next.ovr = OVR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && valid2) begin
      item3 <= item_next;
    end
  end

  assign out_valid = valid3;
  assign out_item  = item3;

  // A stalled first stage keeps its content.
  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    valid1 && !ready2 |=> valid1 && $stable(log1) && $stable(fe1))
    else $error("front end stage 1 changed while stalled");

endmodule

@@ sv/gpc_exp_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamma correction exponential chain
// Builds 2^-frac as a product of fixed roots, one fraction bit and one
// multiplier per register stage, most significant bit first.
// ----------------------------------------------------------------------------
module gpc_exp_chain (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gpc_pkg::exp_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output gpc_pkg::exp_item_t out_item
);
  import gpc_pkg::*;

  localparam int PROD_W = MANT_BITS + ROOT_BITS;

  logic      valid     [FRAC_BITS];
  logic      ready     [FRAC_BITS];
  exp_item_t item      [FRAC_BITS];
  logic      src_valid [FRAC_BITS];
  exp_item_t src_item  [FRAC_BITS];
  logic      dst_ready [FRAC_BITS];

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_step
    logic [PROD_W-1:0] prod;
    exp_item_t         item_next;

    // Neighbouring stages of the chain.
    if (g == 0) begin : g_first
      assign src_valid[g] = in_valid;
      assign src_item[g]  = in_item;
    end else begin : g_inner
      assign src_valid[g] = valid[g-1];
      assign src_item[g]  = item[g-1];
    end
    if (g == FRAC_BITS - 1) begin : g_last
      assign dst_ready[g] = out_ready;
    end else begin : g_mid
      assign dst_ready[g] = ready[g+1];
    end

    assign ready[g] = !valid[g] || dst_ready[g];

    // Multiply by the root for this bit when the bit is set.
    assign prod = PROD_W'(src_item[g].mant) * PROD_W'(ROOT_TABLE[g+1]);

    always_comb begin
      item_next = src_item[g];
      if (src_item[g].frac[FRAC_BITS-1-g]) begin
        item_next.mant = prod[PROD_W-1:Q_BITS];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[g] <= 1'b0;
      end else if (ready[g]) begin
        valid[g] <= src_valid[g];
      end
    end

    always_ff @(posedge clk) begin
      if (ready[g] && src_valid[g]) begin
        item[g] <= item_next;
      end
    end
  end

  assign in_ready  = ready[0];
  assign out_valid = valid[FRAC_BITS-1];
  assign out_item  = item[FRAC_BITS-1];

  // Every factor is below one, so the mantissa never grows past one.
  a_mant_bound: assert property (@(posedge clk) disable iff (rst)
    valid[FRAC_BITS-1] |-> item[FRAC_BITS-1].mant <= ONE_Q30)
    else $error("exponential mantissa exceeds one");

endmodule

@@ sv/gpc_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamma correction output stage
// Scales the mantissa to pixel range, applies the integer shift, rounds
// halves up, saturates and applies the special cases, over two register stages.
// ----------------------------------------------------------------------------
module gpc_out_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gpc_pkg::exp_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gpc_pkg::PIXEL_BITS-1:0] out_pixel,
  output logic                           out_frame_end
);
  import gpc_pkg::*;

  localparam int SUM_BITS = SCALE_BITS + 1;

  logic                    valid_a;
  logic                    valid_b;
  logic                    ready_a;
  logic                    ready_b;
  logic [SCALE_BITS:0]     scale_wide;
  logic [SCALE_BITS-1:0]   scaled_a;
  logic [SHIFT_BITS-1:0]   ipart_a;
  override_t               ovr_a;
  logic                    fe_a;
  logic [SCALE_BITS-1:0]   shifted;
  logic [SUM_BITS-1:0]     rounded;
  logic [SUM_BITS-Q_BITS-1:0] whole;
  logic [PIXEL_BITS-1:0]   pixel_next;
  logic [PIXEL_BITS-1:0]   pixel_b;
  logic                    fe_b;

  assign ready_b  = !valid_b || out_ready;
  assign ready_a  = !valid_a || ready_b;
  assign in_ready = ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else begin
      if (ready_a) valid_a <= in_valid;
      if (ready_b) valid_b <= valid_a;
    end
  end

  // Stage A: multiply by full scale as a shift and a subtract.
  assign scale_wide = {in_item.mant, {(PIXEL_BITS){1'b0}}} - (SCALE_BITS + 1)'(in_item.mant);

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      scaled_a <= scale_wide[SCALE_BITS-1:0];
      ipart_a  <= in_item.ipart;
      ovr_a    <= in_item.ovr;
      fe_a     <= in_item.frame_end;
    end
  end

  // Stage B: shift, round half up, saturate and apply special cases.
  assign shifted = scaled_a >> ipart_a;
  assign rounded = SUM_BITS'(shifted) + SUM_BITS'(64'd1 << (Q_BITS - 1));
  assign whole   = rounded[SUM_BITS-1:Q_BITS];

  always_comb begin
    case (ovr_a)
      OVR_ZERO: pixel_next = '0;
      OVR_FULL: pixel_next = PIXEL_BITS'(PIXEL_MAX);
      OVR_NONE: begin
        if (whole > (SUM_BITS - Q_BITS)'(PIXEL_MAX)) begin
          pixel_next = PIXEL_BITS'(PIXEL_MAX);
        end else begin
          pixel_next = whole[PIXEL_BITS-1:0];
        end
      end
      default: pixel_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ready_b && valid_a) begin
      pixel_b <= pixel_next;
      fe_b    <= fe_a;
    end
  end

  assign out_valid     = valid_b;
  assign out_pixel     = pixel_b;
  assign out_frame_end = fe_b;

endmodule

@@ sv/pixel_gamma_correction.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel gamma correction
// Power-law correction of an 8-bit pixel stream: log2 lookup, scale by the
// Q4.12 exponent register, exp2 by a chain of root multipliers, round.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while the output is not stalled; the 21
// register stages (three front end, sixteen root multipliers, two output)
// each hold one pixel.
// A stalled output holds its pixel while empty stages further up keep filling.
// Reset empties the pipeline and sets the exponent register to identity (4096).
module pixel_gamma_correction (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,    // inverse_gamma, unsigned Q4.12
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
  input  logic        s_axis_tlast,   // frame_end_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] pixel_out
  output logic        m_axis_tlast    // frame_end_out
);
  import gpc_pkg::*;

  localparam int CNT_BITS = $clog2(PIPE_DEPTH + 1);

  logic [EXP_BITS-1:0] inverse_gamma;
  logic                front_valid;
  logic                front_ready;
  exp_item_t           front_item;
  logic                chain_valid;
  logic                chain_ready;
  exp_item_t           chain_item;
  logic [CNT_BITS-1:0] occupancy;
  logic                in_acc;
  logic                out_acc;

  // Exponent register.
  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_gamma <= IDENTITY_EXP;
    end else if (cfg_wr_en) begin
      inverse_gamma <= cfg_wr_data;
    end
  end

  gpc_log_front u_front (
    .clk           (clk),
    .rst           (rst),
    .inverse_gamma (inverse_gamma),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_pixel      (s_axis_tdata),
    .in_frame_end  (s_axis_tlast),
    .out_valid     (front_valid),
    .out_ready     (front_ready),
    .out_item      (front_item)
  );

  gpc_exp_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (chain_valid),
    .out_ready (chain_ready),
    .out_item  (chain_item)
  );

  gpc_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (chain_valid),
    .in_ready      (chain_ready),
    .in_item       (chain_item),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_pixel     (m_axis_tdata),
    .out_frame_end (m_axis_tlast)
  );

  // Count of pixels inside the pipeline, for checking.
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy + CNT_BITS'(in_acc) - CNT_BITS'(out_acc);
    end
  end

  // The pipeline never holds more pixels than it has stages.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_BITS'(PIPE_DEPTH))
    else $error("pipeline holds more pixels than stages");

  // Nothing leaves an empty pipeline.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    occupancy == '0 |-> !m_axis_tvalid)
    else $error("output transaction offered from an empty pipeline");

  // Reset leaves the exponent at identity.
  a_reset_exp: assert property (@(posedge clk)
    rst |=> inverse_gamma == IDENTITY_EXP)
    else $error("exponent register not at identity after reset");

endmodule
